[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the console writer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// types, constants and helpers of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = CELLS - COLUMNS;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SWEEP_W = $clog2(CELLS + 1);

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int STYLE_W   = 8;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 7;
    localparam int OFF_W     = 11;
    localparam int CELL_W    = CHAR_W + STYLE_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0]  NULL_CHAR    = 8'd0;
    localparam logic [STYLE_W-1:0] RESET_STYLE  = 8'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT        = 2'd0,
        CMD_CLEAR      = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_READ       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_PUT     = 3'd1,
        OP_NEWLINE = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_SETCUR  = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  character;
        logic [STYLE_W-1:0] style;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [ADDR_W-1:0]  addr;
    } item_t;

    typedef struct packed {
        logic [OFF_W-1:0]   cursor_offset;
        logic [CHAR_W-1:0]  cell_character;
        logic [STYLE_W-1:0] cell_style;
        logic               scrolled;
    } result_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    function automatic logic [ADDR_W-1:0] cell_offset(input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

[sv/tcw_cmd_if.sv]
// ----------------------------------------------------------------------------
// tcw_cmd_if
// command request channel of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     command;
    logic [tcw_pkg::CHAR_W-1:0]    character;
    logic [tcw_pkg::STYLE_W-1:0]   style;
    logic [tcw_pkg::ROW_IN_W-1:0]  row;
    logic [tcw_pkg::COL_IN_W-1:0]  column;

    modport source (output valid, command, character, style, row, column, input ready);
    modport sink   (input valid, command, character, style, row, column, output ready);
endinterface

`default_nettype wire

[sv/tcw_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcw_rsp_if
// result channel of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::OFF_W-1:0]     cursor_offset;
    logic [tcw_pkg::CHAR_W-1:0]    cell_character;
    logic [tcw_pkg::STYLE_W-1:0]   cell_style;
    logic                          scrolled;

    modport source (output valid, cursor_offset, cell_character, cell_style, scrolled,
                    input ready);
    modport sink   (input valid, cursor_offset, cell_character, cell_style, scrolled,
                    output ready);
endinterface

`default_nettype wire

[sv/tcw_cfg_if.sv]
// ----------------------------------------------------------------------------
// tcw_cfg_if
// default style write channel of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::STYLE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[sv/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text-mode console engine with a 25x80 cell store, cursor and scroll
// ----------------------------------------------------------------------------
// cmd: command requests (put, clear, set cursor, read cell), valid/ready
// rsp: one result per request, in order: cursor offset, read cell, scroll flag
// cfg: write of the default style used for clear and the scrolled-in row
// a request is classified on entry and waits in a two-deep queue for the
// executing side, which owns a single-port-write, single-port-read cell memory
// put, newline, null put and set cursor: result in the cycle after the request
// leaves the queue (a put or newline that scrolls waits for the copy pass);
// one request per cycle sustained while rsp is ready
// read cell: a read state for the registered memory read
// clear: one write per cell; scroll: copy pass; after reset the store is swept
// to spaces in style 7 with cmd.ready low; cfg writes are taken throughout
// when rsp stalls the result register holds, the queue fills and cmd.ready
// drops
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcw_cmd_if.sink    cmd,
    tcw_rsp_if.source  rsp,
    tcw_cfg_if.sink    cfg
);

    logic                   push;
    logic                   pop;
    logic                   init_busy;
    tcw_pkg::item_t         push_item;
    tcw_pkg::item_t         head_item;
    tcw_pkg::queue_status_t q_status;

    tcw_front u_front (
        .cmd       (cmd),
        .init_busy (init_busy),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rsp       (rsp),
        .q_status  (q_status),
        .q_item    (head_item),
        .q_pop     (pop),
        .init_busy (init_busy)
    );

endmodule

`default_nettype wire

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// accepts command requests, classifies them and clamps coordinates
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
    tcw_cmd_if.sink                     cmd,
    input  wire logic                   init_busy,
    input  wire tcw_pkg::queue_status_t q_status,
    output logic                        push,
    output tcw_pkg::item_t              push_item
);

    logic [tcw_pkg::ROW_W-1:0] row_clamped;
    logic [tcw_pkg::COL_W-1:0] col_clamped;
    tcw_pkg::op_t              op;

    assign cmd.ready = !q_status.full && !init_busy;
    assign push      = cmd.valid && cmd.ready;

    assign row_clamped = (32'(cmd.row) > tcw_pkg::ROWS - 1)
                       ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                       : tcw_pkg::ROW_W'(cmd.row);
    assign col_clamped = (32'(cmd.column) > tcw_pkg::COLUMNS - 1)
                       ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
                       : tcw_pkg::COL_W'(cmd.column);

    always_comb
    begin
        unique case (tcw_pkg::cmd_t'(cmd.command))
            tcw_pkg::CMD_PUT:
            begin
                priority if (cmd.character == tcw_pkg::NULL_CHAR)
                    op = tcw_pkg::OP_NOP;
                else if (cmd.character == tcw_pkg::NEWLINE_CHAR)
                    op = tcw_pkg::OP_NEWLINE;
                else
                    op = tcw_pkg::OP_PUT;
            end
            tcw_pkg::CMD_CLEAR:      op = tcw_pkg::OP_CLEAR;
            tcw_pkg::CMD_SET_CURSOR: op = tcw_pkg::OP_SETCUR;
            tcw_pkg::CMD_READ:       op = tcw_pkg::OP_READ;
            default:                 op = tcw_pkg::OP_NOP;
        endcase
    end

    assign push_item = '{
        op:        op,
        character: cmd.character,
        style:     cmd.style,
        row:       row_clamped,
        column:    col_clamped,
        addr:      tcw_pkg::cell_offset(row_clamped, col_clamped)
    };

endmodule

`default_nettype wire

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tcw_pkg::item_t    push_item,
    input  wire logic              pop,
    output tcw_pkg::item_t         head_item,
    output tcw_pkg::queue_status_t status
);

    tcw_pkg::item_t                 store_reg [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::Q_CNT_W-1:0]    count_reg, count_next;

    assign status.full  = (count_reg == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_item    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tcw_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + tcw_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + tcw_pkg::Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - tcw_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    `TCW_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && status.full, "push into full queue")
    `TCW_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !status.valid, "pop from empty queue")

endmodule

`default_nettype wire

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// executes requests: cell memory, cursor, clear and scroll passes, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tcw_cfg_if.sink                     cfg,
    tcw_rsp_if.source                   rsp,
    input  wire tcw_pkg::queue_status_t q_status,
    input  wire tcw_pkg::item_t         q_item,
    output logic                        q_pop,
    output logic                        init_busy
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_SCROLL = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [tcw_pkg::SWEEP_W-1:0]    sweep_reg, sweep_next;
    logic [tcw_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]      col_reg, col_next;
    logic [tcw_pkg::STYLE_W-1:0]    style_reg;
    logic                           out_valid_reg, out_valid_next;
    tcw_pkg::result_t               out_reg, out_next;
    logic [tcw_pkg::CELL_W-1:0]     rd_data_reg;
    logic [tcw_pkg::CELL_W-1:0]     mem [tcw_pkg::CELLS];

    logic                           wr_en;
    logic [tcw_pkg::ADDR_W-1:0]     wr_addr;
    logic [tcw_pkg::CELL_W-1:0]     wr_data;
    logic [tcw_pkg::ADDR_W-1:0]     rd_addr;
    logic                           out_free;
    logic                           load_out;
    logic                           load_cell;
    logic                           load_scrolled;
    logic [tcw_pkg::SWEEP_W-1:0]    sweep_m1;
    logic [tcw_pkg::SWEEP_W-1:0]    sweep_up;
    logic                           last_sweep;
    logic                           at_last_row;
    logic                           at_last_col;
    logic [tcw_pkg::CELL_W-1:0]     blank_cell;

    assign cfg.ready   = 1'b1;
    assign init_busy   = (state_reg == ST_INIT);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign q_pop       = (state_reg == ST_RUN) && q_status.valid && out_free;
    assign sweep_m1    = sweep_reg - tcw_pkg::SWEEP_W'(1);
    assign sweep_up    = sweep_reg + tcw_pkg::SWEEP_W'(tcw_pkg::COLUMNS);
    assign at_last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign at_last_col = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign blank_cell  = {style_reg, tcw_pkg::SPACE_CHAR};

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = tcw_pkg::cell_offset(row_reg, col_reg);
        wr_data        = {q_item.style, q_item.character};
        rd_addr        = q_item.addr;
        load_out       = 1'b0;
        load_cell      = 1'b0;
        load_scrolled  = 1'b0;
        last_sweep     = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg[tcw_pkg::ADDR_W-1:0];
                wr_data    = {tcw_pkg::RESET_STYLE, tcw_pkg::SPACE_CHAR};
                last_sweep = (sweep_reg == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS - 1));
                sweep_next = last_sweep ? '0 : sweep_reg + tcw_pkg::SWEEP_W'(1);
                if (last_sweep)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (q_pop)
                begin
                    unique case (q_item.op)
                        tcw_pkg::OP_NOP:
                            load_out = 1'b1;
                        tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE:
                        begin
                            wr_en = (q_item.op == tcw_pkg::OP_PUT);
                            if ((q_item.op == tcw_pkg::OP_NEWLINE || at_last_col)
                                && at_last_row)
                            begin
                                col_next   = '0;
                                sweep_next = '0;
                                state_next = ST_SCROLL;
                            end
                            else if (q_item.op == tcw_pkg::OP_NEWLINE || at_last_col)
                            begin
                                row_next = row_reg + tcw_pkg::ROW_W'(1);
                                col_next = '0;
                                load_out = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + tcw_pkg::COL_W'(1);
                                load_out = 1'b1;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        tcw_pkg::OP_SETCUR:
                        begin
                            row_next = q_item.row;
                            col_next = q_item.column;
                            load_out = 1'b1;
                        end
                        tcw_pkg::OP_READ:
                            state_next = ST_READ;
                        default:
                            load_out = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                load_out   = 1'b1;
                load_cell  = 1'b1;
                state_next = ST_RUN;
            end
            ST_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg[tcw_pkg::ADDR_W-1:0];
                wr_data    = blank_cell;
                last_sweep = (sweep_reg == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS - 1));
                sweep_next = last_sweep ? '0 : sweep_reg + tcw_pkg::SWEEP_W'(1);
                if (last_sweep)
                begin
                    load_out   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_SCROLL:
            begin
                // read the cell in the row below; the registered read data is written at the previous sweep address
                rd_addr = (sweep_reg < tcw_pkg::SWEEP_W'(tcw_pkg::COPY_CELLS))
                        ? sweep_up[tcw_pkg::ADDR_W-1:0] : '0;
                wr_en   = (sweep_reg != '0);
                wr_addr = sweep_m1[tcw_pkg::ADDR_W-1:0];
                wr_data = (sweep_reg <= tcw_pkg::SWEEP_W'(tcw_pkg::COPY_CELLS))
                        ? rd_data_reg : blank_cell;
                last_sweep = (sweep_reg == tcw_pkg::SWEEP_W'(tcw_pkg::CELLS));
                sweep_next = last_sweep ? '0 : sweep_reg + tcw_pkg::SWEEP_W'(1);
                if (last_sweep)
                begin
                    load_out      = 1'b1;
                    load_scrolled = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next = '{
                cursor_offset:  tcw_pkg::OFF_W'(tcw_pkg::cell_offset(row_next, col_next)),
                cell_character: load_cell ? rd_data_reg[tcw_pkg::CHAR_W-1:0] : '0,
                cell_style:     load_cell ? rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W]
                                          : '0,
                scrolled:       load_scrolled
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            style_reg     <= tcw_pkg::RESET_STYLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                style_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.cursor_offset  = out_reg.cursor_offset;
    assign rsp.cell_character = out_reg.cell_character;
    assign rsp.cell_style     = out_reg.cell_style;
    assign rsp.scrolled       = out_reg.scrolled;

    `TCW_ASSERT(a_scroll_out_empty, clk, rst_n, (state_reg == ST_SCROLL) |-> !out_valid_reg, "result pending during scroll")
    `TCW_ASSERT(a_read_loads_out, clk, rst_n, (state_reg == ST_READ) |=> out_valid_reg, "read result not loaded")
    `TCW_ASSERT(a_scroll_cursor, clk, rst_n, (out_valid_reg && out_reg.scrolled) |-> (out_reg.cursor_offset == tcw_pkg::OFF_W'(tcw_pkg::COPY_CELLS)), "scroll left cursor off bottom row")

endmodule

`default_nettype wire
